[hw/rtl/nspdu_pkg.sv]
// Shared types, codes and helpers for the NS PDU parser.
`timescale 1ns / 1ps
package nspdu_pkg;

  // Parse phases
  localparam logic [3:0] PH_TYPE     = 4'd0;
  localparam logic [3:0] PH_IGNORE   = 4'd1;
  localparam logic [3:0] PH_SPARE    = 4'd2;
  localparam logic [3:0] PH_BVCI_HI  = 4'd3;
  localparam logic [3:0] PH_BVCI_LO  = 4'd4;
  localparam logic [3:0] PH_PAYLOAD  = 4'd5;
  localparam logic [3:0] PH_TLV_TYPE = 4'd6;
  localparam logic [3:0] PH_LEN1     = 4'd7;
  localparam logic [3:0] PH_LEN2     = 4'd8;
  localparam logic [3:0] PH_VALUE    = 4'd9;
  localparam logic [3:0] PH_SKIP     = 4'd10;

  // Event kinds
  localparam logic [3:0] EV_PDU_TYPE  = 4'd0;
  localparam logic [3:0] EV_UD_BVCI   = 4'd1;
  localparam logic [3:0] EV_PAYLOAD   = 4'd2;
  localparam logic [3:0] EV_CAUSE     = 4'd3;
  localparam logic [3:0] EV_NSVCI     = 4'd4;
  localparam logic [3:0] EV_BVCI      = 4'd5;
  localparam logic [3:0] EV_NSEI      = 4'd6;
  localparam logic [3:0] EV_BAD_LEN   = 4'd7;
  localparam logic [3:0] EV_ERROR_PDU = 4'd8;
  localparam logic [3:0] EV_UNKNOWN   = 4'd9;
  localparam logic [3:0] EV_TRUNC     = 4'd10;
  localparam logic [3:0] EV_END       = 4'd11;

  // PDU types
  localparam logic [7:0] PDU_UNITDATA  = 8'h00;
  localparam logic [7:0] PDU_RESET     = 8'h02;
  localparam logic [7:0] PDU_RESET_ACK = 8'h03;
  localparam logic [7:0] PDU_BLOCK     = 8'h04;
  localparam logic [7:0] PDU_BLOCK_ACK = 8'h05;
  localparam logic [7:0] PDU_STATUS    = 8'h08;

  // Element types
  localparam logic [7:0] IE_CAUSE  = 8'h00;
  localparam logic [7:0] IE_NSVCI  = 8'h01;
  localparam logic [7:0] IE_NS_PDU = 8'h02;
  localparam logic [7:0] IE_BVCI   = 8'h03;
  localparam logic [7:0] IE_NSEI   = 8'h04;

  typedef struct packed {
    logic [3:0]  phase;
    logic [7:0]  tlv_type;
    logic [14:0] tlv_length;
    logic [14:0] bytes_left;
    logic [15:0] acc;
  } parse_state_t;

  typedef struct packed {
    logic        valid;
    logic [3:0]  kind;
    logic [15:0] value;
    logic [7:0]  etype;
    logic [14:0] elen;
    logic        pend;
  } result_t;

  function automatic logic is_id_element(input logic [7:0] t);
    return (t == IE_NSVCI) || (t == IE_BVCI) || (t == IE_NSEI);
  endfunction

  function automatic logic is_tlv_pdu(input logic [7:0] t);
    return (t == PDU_RESET) || (t == PDU_RESET_ACK) || (t == PDU_BLOCK) ||
           (t == PDU_BLOCK_ACK) || (t == PDU_STATUS);
  endfunction

endpackage

[hw/rtl/nspdu_step.sv]
// Per-word parse step: next state and result for one PDU octet.
`timescale 1ns / 1ps
module nspdu_step import nspdu_pkg::*; (
  input  parse_state_t st,
  input  logic [7:0]   data_byte,
  input  logic         last_byte,
  output parse_state_t st_next,
  output result_t      res
);

  always_comb begin
    parse_state_t n;
    logic         has_ev;
    logic [3:0]   kind;
    logic [15:0]  val;
    logic [14:0]  len;
    logic         len_known;
    logic [14:0]  left_dec;
    logic         in_field;

    n         = st;
    has_ev    = 1'b0;
    kind      = EV_END;
    val       = '0;
    len       = '0;
    len_known = 1'b0;
    left_dec  = (st.bytes_left != '0) ? st.bytes_left - 15'd1 : st.bytes_left;

    case (st.phase)
      PH_TYPE: begin
        has_ev = 1'b1;
        kind   = EV_PDU_TYPE;
        val    = {8'h00, data_byte};
        if (data_byte == PDU_UNITDATA) begin
          n.phase = PH_SPARE;
        end else if (is_tlv_pdu(data_byte)) begin
          n.phase = PH_TLV_TYPE;
        end else begin
          n.phase = PH_IGNORE;
        end
      end
      PH_IGNORE: begin
      end
      PH_SPARE: begin
        n.phase = PH_BVCI_HI;
      end
      PH_BVCI_HI: begin
        n.acc   = {8'h00, data_byte};
        n.phase = PH_BVCI_LO;
      end
      PH_BVCI_LO: begin
        n.acc   = {st.acc[7:0], data_byte};
        has_ev  = 1'b1;
        kind    = EV_UD_BVCI;
        val     = {st.acc[7:0], data_byte};
        n.phase = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        has_ev = 1'b1;
        kind   = EV_PAYLOAD;
        val    = {8'h00, data_byte};
      end
      PH_TLV_TYPE: begin
        n.tlv_type   = data_byte;
        n.tlv_length = '0;
        n.phase      = PH_LEN1;
      end
      PH_LEN1: begin
        if (data_byte[7]) begin
          len       = {8'h00, data_byte[6:0]};
          len_known = 1'b1;
        end else begin
          n.acc   = {8'h00, data_byte};
          n.phase = PH_LEN2;
        end
      end
      PH_LEN2: begin
        len       = {st.acc[6:0], data_byte};
        len_known = 1'b1;
      end
      PH_VALUE: begin
        n.acc        = {st.acc[7:0], data_byte};
        n.bytes_left = left_dec;
        if (left_dec == '0) begin
          has_ev = 1'b1;
          val    = {st.acc[7:0], data_byte};
          if (st.tlv_type == IE_CAUSE) begin
            kind = EV_CAUSE;
          end else if (st.tlv_type == IE_NSVCI) begin
            kind = EV_NSVCI;
          end else if (st.tlv_type == IE_BVCI) begin
            kind = EV_BVCI;
          end else begin
            kind = EV_NSEI;
          end
          n.phase = PH_TLV_TYPE;
        end
      end
      PH_SKIP: begin
        n.bytes_left = left_dec;
        if (left_dec == '0) begin
          n.phase = PH_TLV_TYPE;
        end
      end
      default: begin
        n.phase = PH_IGNORE;
      end
    endcase

    // Length complete: check it against the element type
    if (len_known) begin
      n.tlv_length = len;
      n.bytes_left = len;
      if (((st.tlv_type == IE_CAUSE) && (len == 15'd1)) ||
          (is_id_element(st.tlv_type) && (len == 15'd2))) begin
        n.acc   = '0;
        n.phase = PH_VALUE;
      end else begin
        has_ev = 1'b1;
        if ((st.tlv_type == IE_CAUSE) || is_id_element(st.tlv_type)) begin
          kind = EV_BAD_LEN;
        end else if (st.tlv_type == IE_NS_PDU) begin
          kind = EV_ERROR_PDU;
        end else begin
          kind = EV_UNKNOWN;
        end
        n.phase = (len != '0) ? PH_SKIP : PH_TLV_TYPE;
      end
    end

    res.valid = has_ev;
    res.kind  = kind;
    res.value = val;
    res.pend  = last_byte;
    if (has_ev && (kind >= EV_CAUSE)) begin
      res.etype = n.tlv_type;
      res.elen  = n.tlv_length;
    end else begin
      res.etype = '0;
      res.elen  = '0;
    end

    if (last_byte) begin
      in_field = (n.phase == PH_SPARE) || (n.phase == PH_BVCI_HI) ||
                 (n.phase == PH_BVCI_LO) || (n.phase == PH_LEN1) ||
                 (n.phase == PH_LEN2) || (n.phase == PH_VALUE) ||
                 (n.phase == PH_SKIP);
      if (in_field) begin
        res.valid = 1'b1;
        res.kind  = EV_TRUNC;
        res.value = '0;
        res.etype = (n.phase >= PH_LEN1) ? n.tlv_type : 8'h00;
        res.elen  = (n.phase >= PH_VALUE) ? n.tlv_length : 15'd0;
      end else if (!has_ev) begin
        res.valid = 1'b1;
        res.kind  = EV_END;
        res.value = '0;
        res.etype = '0;
        res.elen  = '0;
      end
      // Return to reset state after the final octet
      n.phase      = PH_TYPE;
      n.tlv_type   = '0;
      n.tlv_length = '0;
      n.bytes_left = '0;
      n.acc        = '0;
    end else begin
      in_field = 1'b0;
    end

    st_next = n;
  end

endmodule

[hw/rtl/gprs_ns_pdu_tlv_parser.sv]
// Top level of the NS PDU parser: input register, parse state, result register.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------------------
//   in      | sink      | in_valid / in_ready  | data_byte, last_byte
//   out     | source    | out_valid / out_ready| event_kind, field_value, element_type,
//           |           |                      | element_length, pdu_end
//
// One word per cycle sustained while the output is not stalled; a taken word passes through
// the input register, then one parse step into the result register.
// Words with no event produce nothing on the output; the final word of a PDU always does.
// Reset (rst, synchronous) clears the parse state and both register valid flags.
// A stalled output holds the result and backs up into the input register and in_ready.
`timescale 1ns / 1ps
module gprs_ns_pdu_tlv_parser import nspdu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  event_kind,
  output logic [15:0] field_value,
  output logic [7:0]  element_type,
  output logic [14:0] element_length,
  output logic        pdu_end
);

  logic         s1_valid;
  logic [7:0]   s1_byte;
  logic         s1_last;
  logic         advance;
  parse_state_t st;
  parse_state_t st_next;
  result_t      res;
  result_t      out_reg;

  nspdu_step u_step (
    .st        (st),
    .data_byte (s1_byte),
    .last_byte (s1_last),
    .st_next   (st_next),
    .res       (res)
  );

  assign advance  = s1_valid && (!out_reg.valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_byte <= data_byte;
      s1_last <= last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase      <= PH_TYPE;
      st.tlv_type   <= '0;
      st.tlv_length <= '0;
      st.bytes_left <= '0;
      st.acc        <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_reg.valid <= 1'b0;
    end else if (advance) begin
      out_reg <= res;
    end else if (out_ready) begin
      // drop the delivered word
      out_reg.valid <= 1'b0;
    end
  end

  assign out_valid      = out_reg.valid;
  assign event_kind     = out_reg.kind;
  assign field_value    = out_reg.value;
  assign element_type   = out_reg.etype;
  assign element_length = out_reg.elen;
  assign pdu_end        = out_reg.pend;

  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_last) |=> (st.phase == PH_TYPE))
    else $error("parse state not back to type phase after final word");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_last) |=> (out_valid && pdu_end))
    else $error("final word produced no result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !advance)
    else $error("parse step advanced into a stalled result register");

  a_etype_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (event_kind == EV_PDU_TYPE || event_kind == EV_UD_BVCI ||
                   event_kind == EV_PAYLOAD || event_kind == EV_END))
      |-> (element_type == 8'h00 && element_length == 15'd0))
    else $error("element fields set on a non-element event");

  a_end_only_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (event_kind == EV_TRUNC || event_kind == EV_END)) |-> pdu_end)
    else $error("truncated or end event without final mark");

endmodule

[tb/sv/gprs_ns_pdu_tlv_parser_tb.sv]
// Self-checking testbench for the NS PDU parser: directed and random PDUs checked per event.
`timescale 1ns / 1ps
module gprs_ns_pdu_tlv_parser_tb;
  import nspdu_pkg::*;

  localparam int WORD_TARGET  = 1850;
  localparam int IDLE_PCT     = 22;
  localparam int HOLD_AT      = 700;
  localparam int HOLD_CYCLES  = 150;
  localparam int QUIET_FROM   = 1100;
  localparam int QUIET_TO     = 1400;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [7:0] octet;
    logic       fin;
  } pdu_word_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] value;
    logic [7:0]  etype;
    logic [14:0] elen;
    logic        pend;
  } ns_event_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  event_kind;
  logic [15:0] field_value;
  logic [7:0]  element_type;
  logic [14:0] element_length;
  logic        pdu_end;

  pdu_word_t  pending_words[$];
  ns_event_t  expected_events[$];
  logic [7:0] pdu_bytes[$];
  int         words_taken = 0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;
  int         errors = 0;

  // parser state as the predictor sees it
  logic [3:0]  p_phase;
  logic [7:0]  p_ie;
  logic [14:0] p_len;
  logic [14:0] p_left;
  logic [15:0] p_acc;

  gprs_ns_pdu_tlv_parser dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .event_kind(event_kind),
    .field_value(field_value),
    .element_type(element_type),
    .element_length(element_length),
    .pdu_end(pdu_end)
  );

  always #2 clk = ~clk;

  function automatic void clear_parse_state();
    p_phase = PH_TYPE;
    p_ie    = '0;
    p_len   = '0;
    p_left  = '0;
    p_acc   = '0;
  endfunction

  // Advance the parser by one octet; return 1 when the octet yields an event.
  function automatic bit parse_octet(input logic [7:0] b, input logic last,
                                     output ns_event_t ev);
    bit          hit;
    bit          len_ready;
    bit          id_ie;
    logic [3:0]  kind;
    logic [15:0] val;
    logic [7:0]  et;
    logic [14:0] el;
    hit = 1'b0;
    len_ready = 1'b0;
    kind = EV_END;
    val = '0;
    et = '0;
    el = '0;
    case (p_phase)
      PH_TYPE: begin
        hit = 1'b1;
        kind = EV_PDU_TYPE;
        val = {8'h00, b};
        if (b == PDU_UNITDATA) p_phase = PH_SPARE;
        else if (b == PDU_RESET || b == PDU_RESET_ACK || b == PDU_BLOCK ||
                 b == PDU_BLOCK_ACK || b == PDU_STATUS) p_phase = PH_TLV_TYPE;
        else p_phase = PH_IGNORE;
      end
      PH_IGNORE: ;
      PH_SPARE: p_phase = PH_BVCI_HI;
      PH_BVCI_HI: begin
        p_acc = {8'h00, b};
        p_phase = PH_BVCI_LO;
      end
      PH_BVCI_LO: begin
        p_acc = {p_acc[7:0], b};
        hit = 1'b1;
        kind = EV_UD_BVCI;
        val = p_acc;
        p_phase = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        hit = 1'b1;
        kind = EV_PAYLOAD;
        val = {8'h00, b};
      end
      PH_TLV_TYPE: begin
        p_ie = b;
        p_len = '0;
        p_phase = PH_LEN1;
      end
      PH_LEN1: begin
        if (b[7]) begin
          p_len = {8'h00, b[6:0]};
          len_ready = 1'b1;
        end else begin
          p_acc = {8'h00, b};
          p_phase = PH_LEN2;
        end
      end
      PH_LEN2: begin
        p_len = {p_acc[6:0], b};
        len_ready = 1'b1;
      end
      PH_VALUE: begin
        p_acc = {p_acc[7:0], b};
        if (p_left != 0) p_left = p_left - 1'b1;
        if (p_left == 0) begin
          hit = 1'b1;
          case (p_ie)
            IE_CAUSE: kind = EV_CAUSE;
            IE_NSVCI: kind = EV_NSVCI;
            IE_BVCI:  kind = EV_BVCI;
            default:  kind = EV_NSEI;
          endcase
          val = p_acc;
          p_phase = PH_TLV_TYPE;
        end
      end
      PH_SKIP: begin
        if (p_left != 0) p_left = p_left - 1'b1;
        if (p_left == 0) p_phase = PH_TLV_TYPE;
      end
      default: p_phase = PH_IGNORE;
    endcase

    if (len_ready) begin
      id_ie = (p_ie == IE_NSVCI) || (p_ie == IE_BVCI) || (p_ie == IE_NSEI);
      p_left = p_len;
      if ((p_ie == IE_CAUSE && p_len == 1) || (id_ie && p_len == 2)) begin
        p_acc = '0;
        p_phase = PH_VALUE;
      end else begin
        hit = 1'b1;
        if (p_ie == IE_CAUSE || id_ie) kind = EV_BAD_LEN;
        else if (p_ie == IE_NS_PDU) kind = EV_ERROR_PDU;
        else kind = EV_UNKNOWN;
        p_phase = (p_len != 0) ? PH_SKIP : PH_TLV_TYPE;
      end
    end

    if (hit && kind >= EV_CAUSE) begin
      et = p_ie;
      el = p_len;
    end

    if (last) begin
      if (p_phase inside {PH_SPARE, PH_BVCI_HI, PH_BVCI_LO, PH_LEN1, PH_LEN2,
                          PH_VALUE, PH_SKIP}) begin
        kind = EV_TRUNC;
        val = '0;
        et = (p_phase >= PH_LEN1) ? p_ie : 8'h00;
        el = (p_phase >= PH_VALUE) ? p_len : 15'h0000;
      end else if (!hit) begin
        kind = EV_END;
        val = '0;
        et = '0;
        el = '0;
      end
      hit = 1'b1;
      clear_parse_state();
    end

    ev.kind = kind;
    ev.value = val;
    ev.etype = et;
    ev.elen = el;
    ev.pend = last;
    return hit;
  endfunction

  function automatic bit quiet_now();
    return words_taken >= QUIET_FROM && words_taken < QUIET_TO;
  endfunction

  // Queue the first keep octets of the PDU under construction, marking the final one.
  function automatic void flush_pdu(input int keep);
    pdu_word_t w;
    for (int i = 0; i < keep; i++) begin
      w.octet = pdu_bytes[i];
      w.fin = (i == keep - 1);
      pending_words.push_back(w);
    end
    pdu_bytes.delete();
  endfunction

  function automatic void put_len(input logic [14:0] len, input bit long_form);
    if (long_form || len > 127) begin
      pdu_bytes.push_back({1'b0, len[14:8]});
      pdu_bytes.push_back(len[7:0]);
    end else begin
      pdu_bytes.push_back({1'b1, len[6:0]});
    end
  endfunction

  function automatic logic [7:0] pick_checked_ie();
    case ($urandom_range(0, 3))
      0:       return IE_CAUSE;
      1:       return IE_NSVCI;
      2:       return IE_BVCI;
      default: return IE_NSEI;
    endcase
  endfunction

  function automatic logic [7:0] pick_tlv_pdu();
    case ($urandom_range(0, 4))
      0:       return PDU_RESET;
      1:       return PDU_RESET_ACK;
      2:       return PDU_BLOCK;
      3:       return PDU_BLOCK_ACK;
      default: return PDU_STATUS;
    endcase
  endfunction

  // Append one element; return 1 when its length is too big to send whole.
  function automatic bit add_element();
    int         sel;
    int         len;
    int         proper;
    logic [7:0] ie;
    bit         huge;
    sel = $urandom_range(0, 9);
    huge = 1'b0;
    case (sel)
      0, 1, 2, 3, 4: begin
        ie = pick_checked_ie();
        len = (ie == IE_CAUSE) ? 1 : 2;
      end
      5, 6: begin
        ie = pick_checked_ie();
        proper = (ie == IE_CAUSE) ? 1 : 2;
        do len = $urandom_range(0, 5); while (len == proper);
      end
      7: begin
        ie = IE_NS_PDU;
        len = $urandom_range(0, 6);
      end
      8: begin
        ie = 8'($urandom_range(IE_NSEI + 1, 255));
        len = $urandom_range(0, 6);
      end
      default: begin
        ie = 8'($urandom_range(0, 255));
        len = $urandom_range(128, 32767);
        huge = 1'b1;
      end
    endcase
    pdu_bytes.push_back(ie);
    put_len(15'(len), 1'($urandom_range(0, 1)));
    for (int i = 0; i < (huge ? 3 : len); i++) pdu_bytes.push_back(8'($urandom_range(0, 255)));
    return huge;
  endfunction

  function automatic void random_pdu();
    int         r;
    int         keep;
    logic [7:0] t;
    bit         stop;
    r = $urandom_range(0, 99);
    stop = 1'b0;
    if (r < 25) begin
      pdu_bytes.push_back(PDU_UNITDATA);
      repeat ($urandom_range(3, 11)) pdu_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (r < 85) begin
      pdu_bytes.push_back(pick_tlv_pdu());
      repeat ($urandom_range(0, 4)) if (!stop) stop = add_element();
    end else if (r < 93) begin
      do t = 8'($urandom_range(0, 255));
      while (t == PDU_UNITDATA || t == PDU_RESET || t == PDU_RESET_ACK ||
             t == PDU_BLOCK || t == PDU_BLOCK_ACK || t == PDU_STATUS);
      pdu_bytes.push_back(t);
      repeat ($urandom_range(0, 4)) pdu_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 6)) pdu_bytes.push_back(8'($urandom_range(0, 255)));
    end
    keep = pdu_bytes.size();
    // cut some PDUs short at a random octet
    if ($urandom_range(0, 99) < 15) keep = $urandom_range(1, keep);
    flush_pdu(keep);
  endfunction

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
      errors = errors + 1;
    end
  endtask

  always @(posedge clk) begin : drive
    pdu_word_t w;
    ns_event_t ev;
    if (rst) begin
      in_valid <= 1'b0;
      clear_parse_state();
    end else begin
      if (in_valid && in_ready) begin
        if (parse_octet(data_byte, last_byte, ev)) expected_events.push_back(ev);
        words_taken <= words_taken + 1;
      end
      // hold the current word until it is taken
      if (!in_valid || in_ready) begin
        if (pending_words.size() != 0 &&
            (quiet_now() || $urandom_range(0, 99) >= IDLE_PCT)) begin
          w = pending_words.pop_front();
          in_valid <= 1'b1;
          data_byte <= w.octet;
          last_byte <= w.fin;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Stall the output once for a long stretch so the input backs up.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && words_taken >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin : watch
    ns_event_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected word: kind %0d value %h type %h length %h end %b",
                   $time, event_kind, field_value, element_type, element_length, pdu_end);
          errors = errors + 1;
        end else begin
          want = expected_events.pop_front();
          check_field("event_kind", {12'h000, want.kind}, {12'h000, event_kind});
          check_field("field_value", want.value, field_value);
          check_field("element_type", {8'h00, want.etype}, {8'h00, element_type});
          check_field("element_length", {1'b0, want.elen}, {1'b0, element_length});
          check_field("pdu_end", {15'h0000, want.pend}, {15'h0000, pdu_end});
        end
      end
      out_ready <= hold_left == 0 && (quiet_now() || $urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin
    // unitdata: spare, BVCI, one payload octet
    pdu_bytes = '{PDU_UNITDATA, 8'hA5, 8'hFF, 8'h00, 8'h7F};
    flush_pdu(pdu_bytes.size());
    // reset: NSVCI, BVCI, then NSEI with a bad length on the final octet
    pdu_bytes = '{PDU_RESET, IE_NSVCI, 8'h82, 8'h00, 8'h01, IE_BVCI, 8'h82, 8'hFF, 8'hFE,
                  IE_NSEI, 8'h81};
    flush_pdu(pdu_bytes.size());
    // status: cause, empty NS PDU element, unknown element cut after its length
    pdu_bytes = '{PDU_STATUS, IE_CAUSE, 8'h81, 8'h00, IE_NS_PDU, 8'h80, 8'h7E, 8'h00,
                  8'h01};
    flush_pdu(pdu_bytes.size());
    // block: cause with the largest length, cut while skipping
    pdu_bytes = '{PDU_BLOCK, IE_CAUSE, 8'h7F, 8'hFF, 8'h55};
    flush_pdu(pdu_bytes.size());
    // unlisted type: rest ignored, ends plainly
    pdu_bytes = '{8'hFF, 8'h12};
    flush_pdu(pdu_bytes.size());
    // unitdata cut at the spare
    pdu_bytes = '{PDU_UNITDATA};
    flush_pdu(pdu_bytes.size());
    // reset ack cut after the element type
    pdu_bytes = '{PDU_RESET_ACK, IE_NSEI};
    flush_pdu(pdu_bytes.size());

    while (pending_words.size() < WORD_TARGET) random_pdu();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending_words.size() != 0 || in_valid) @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && expected_events.size() == 0) begin
      $display("gprs_ns_pdu_tlv_parser test passed");
    end else begin
      $display("gprs_ns_pdu_tlv_parser test failed");
    end
    $finish;
  end

  initial begin
    #800000;
    $display("gprs_ns_pdu_tlv_parser test failed");
    $finish;
  end

endmodule
